>>> rtl/wvf_pkg.sv
// ----------------------------------------------------------------------------
// wvf_pkg
// Shared types and constants of the video frame WebSocket framer.
// ----------------------------------------------------------------------------
`default_nettype none

package wvf_pkg;

  // item opcodes
  typedef enum logic {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } op_t;

  // frame kind codes; every other code is dropped
  localparam logic [1:0] KIND_DELTA = 2'd0;
  localparam logic [1:0] KIND_KEY   = 2'd1;

  // WebSocket header
  localparam logic [7:0] WS_FIN          = 8'h80;
  localparam logic [7:0] WS_OP_BINARY    = 8'h02;
  localparam logic [7:0] WS_MASK_FLAG    = 8'h80;
  localparam logic [7:0] WS_LEN_CODE_16  = 8'd126;
  localparam logic [7:0] WS_LEN_CODE_64  = 8'd127;
  localparam logic [24:0] WS_LEN7_LIMIT  = 25'd126;
  localparam logic [24:0] WS_LEN16_LIMIT = 25'd65536;

  // record
  localparam logic [31:0] REC_MAGIC   = 32'h342E5452;
  localparam logic [31:0] TEMPL_KEY   = 32'h354B0000;
  localparam logic [31:0] TEMPL_DELTA = 32'h35500000;
  localparam logic [24:0] REC_LEN     = 25'd12;

  // byte counter of the back end
  localparam int CNT_W = 4;
  localparam logic [CNT_W-1:0] CNT_REC_LAST  = 4'd11;
  localparam logic [CNT_W-1:0] CNT_KEY_LAST  = 4'd3;
  localparam logic [CNT_W-1:0] CNT_HDR7_LAST  = 4'd1;
  localparam logic [CNT_W-1:0] CNT_HDR16_LAST = 4'd3;
  localparam logic [CNT_W-1:0] CNT_HDR64_LAST = 4'd9;

  typedef enum logic [1:0] {
    FORM_7  = 2'd0,
    FORM_16 = 2'd1,
    FORM_64 = 2'd2
  } len_form_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_HDR  = 2'd1,
    BK_KEY  = 2'd2,
    BK_REC  = 2'd3
  } bk_state_t;

  // one queued command: either a frame start or one payload byte
  typedef struct packed {
    logic        is_start;
    logic        key_frame;
    logic [23:0] plen;
    logic [24:0] total;
    len_form_t   form;
    logic        cm;
    logic [31:0] key;
    logic [31:0] seq;
    logic [7:0]  data;
    logic        last;
  } qent_t;

endpackage

`default_nettype wire

>>> rtl/websocket_video_frame_framer.sv
// ----------------------------------------------------------------------------
// websocket_video_frame_framer
// Wraps encoded video frames as binary WebSocket frames with a 12-byte
// record and optional client masking.
// ----------------------------------------------------------------------------
// Payload beats pass at one byte per cycle while the back end is idle and the
// output is not stalled; each is registered in the command queue and then in
// the output register. A start beat expands into 14 to 26 output bytes (2, 4
// or 10 header bytes, 4 mask key bytes when masking, 12 record bytes), one per
// cycle from the back end's byte sequencer while the output is not stalled;
// meanwhile the front end keeps taking beats until the command queue
// (QUEUE_DEPTH entries) is full. Unknown kinds and payload bytes outside an
// open frame are dropped at the input; they are accepted but push no command.
`default_nettype none

module websocket_video_frame_framer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         in_op,
  input  wire  [1:0]  in_frame_kind,
  input  wire  [23:0] in_payload_len,
  input  wire         in_client_mask,
  input  wire  [31:0] in_mask_key,
  input  wire  [7:0]  in_data_byte,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [7:0]  out_byte,
  output logic        out_in_header,
  output logic        out_frame_end
);

  wvf_pkg::qent_t q_wdata, q_rdata;
  logic           q_push, q_pop, q_full, q_valid;

  wvf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_frame_kind  (in_frame_kind),
    .in_payload_len (in_payload_len),
    .in_client_mask (in_client_mask),
    .in_mask_key    (in_mask_key),
    .in_data_byte   (in_data_byte),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  wvf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wdata   (q_wdata),
    .full    (q_full),
    .q_valid (q_valid),
    .pop     (q_pop),
    .rdata   (q_rdata)
  );

  wvf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_rdata       (q_rdata),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_in_header (out_in_header),
    .out_frame_end (out_frame_end)
  );

endmodule

`default_nettype wire

>>> rtl/wvf_front.sv
// ----------------------------------------------------------------------------
// wvf_front
// Accepts items, drops unknown kinds and stray bytes, tracks the open frame
// and the sequence number, and pushes commands into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module wvf_front (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire               in_op,
  input  wire  [1:0]        in_frame_kind,
  input  wire  [23:0]       in_payload_len,
  input  wire               in_client_mask,
  input  wire  [31:0]       in_mask_key,
  input  wire  [7:0]        in_data_byte,
  input  wire               q_full,
  output logic              q_push,
  output wvf_pkg::qent_t    q_wdata
);

  logic [31:0] seq_r, seq_nxt;
  logic [23:0] bl_r, bl_nxt;
  logic        open_r, open_nxt;
  logic        accept, is_start, kind_ok, byte_ok;
  logic [24:0] total;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_start = (in_op == wvf_pkg::OP_START);
  assign kind_ok  = (in_frame_kind == wvf_pkg::KIND_DELTA) ||
                    (in_frame_kind == wvf_pkg::KIND_KEY);
  assign byte_ok  = open_r && (bl_r != 24'd0);
  assign total    = {1'b0, in_payload_len} + wvf_pkg::REC_LEN;

  assign q_push = accept && (is_start ? kind_ok : byte_ok);

  always_comb begin
    q_wdata.is_start  = is_start;
    q_wdata.key_frame = (in_frame_kind == wvf_pkg::KIND_KEY);
    q_wdata.plen      = in_payload_len;
    q_wdata.total     = total;
    if (total < wvf_pkg::WS_LEN7_LIMIT) begin
      q_wdata.form = wvf_pkg::FORM_7;
    end else if (total < wvf_pkg::WS_LEN16_LIMIT) begin
      q_wdata.form = wvf_pkg::FORM_16;
    end else begin
      q_wdata.form = wvf_pkg::FORM_64;
    end
    q_wdata.cm   = in_client_mask;
    q_wdata.key  = in_mask_key;
    q_wdata.seq  = seq_r;
    q_wdata.data = in_data_byte;
    q_wdata.last = (bl_r == 24'd1);
  end

  always_comb begin
    seq_nxt  = seq_r;
    bl_nxt   = bl_r;
    open_nxt = open_r;
    if (q_push) begin
      if (is_start) begin
        seq_nxt  = seq_r + 32'd1;
        bl_nxt   = in_payload_len;
        open_nxt = (in_payload_len != 24'd0);
      end else begin
        bl_nxt   = bl_r - 24'd1;
        open_nxt = (bl_r != 24'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r  <= 32'd0;
      bl_r   <= 24'd0;
      open_r <= 1'b0;
    end else begin
      seq_r  <= seq_nxt;
      bl_r   <= bl_nxt;
      open_r <= open_nxt;
    end
  end

  // an open frame always has bytes outstanding
  a_open_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> (bl_r != 24'd0))
    else $error("front: frame open with no bytes left");

endmodule

`default_nettype wire

>>> rtl/wvf_queue.sv
// ----------------------------------------------------------------------------
// wvf_queue
// Short register FIFO of commands between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module wvf_queue #(
  parameter int DEPTH = 2
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               push,
  input  wvf_pkg::qent_t    wdata,
  output logic              full,
  output logic              q_valid,
  input  wire               pop,
  output wvf_pkg::qent_t    rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  wvf_pkg::qent_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign q_valid = (cnt_r != '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    unique case ({push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue: push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("queue: pop while empty");

endmodule

`default_nettype wire

>>> rtl/wvf_back.sv
// ----------------------------------------------------------------------------
// wvf_back
// Walks header, mask key and record bytes of a frame start, passes payload
// bytes, applies the rolling mask and holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wvf_back (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               q_valid,
  input  wvf_pkg::qent_t    q_rdata,
  output logic              q_pop,
  output logic              out_valid,
  input  wire               out_ready,
  output logic [7:0]        out_byte,
  output logic              out_in_header,
  output logic              out_frame_end
);

  wvf_pkg::bk_state_t            st_r, st_nxt;
  logic [wvf_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  wvf_pkg::qent_t                ent_r;
  logic [1:0]                    phase_r, phase_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [7:0]                    out_byte_r, byte_nxt, raw_byte, mask_byte;
  logic                          out_hdr_r, hdr_nxt;
  logic                          out_end_r, end_nxt;
  logic                          advance, fire, load, mask_use;
  logic [wvf_pkg::CNT_W-1:0]     hdr_last;
  logic [7:0]                    hdr_byte, mflag;
  logic [31:0]                   rec_word, templ;

  assign advance = !out_valid_r || out_ready;
  assign q_pop   = (st_r == wvf_pkg::BK_IDLE) && advance && q_valid;
  assign fire    = q_pop;

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_in_header = out_hdr_r;
  assign out_frame_end = out_end_r;

  assign mflag = ent_r.cm ? wvf_pkg::WS_MASK_FLAG : 8'h00;
  assign templ = ent_r.key_frame ? wvf_pkg::TEMPL_KEY : wvf_pkg::TEMPL_DELTA;

  always_comb begin
    unique case (ent_r.form)
      wvf_pkg::FORM_16: hdr_last = wvf_pkg::CNT_HDR16_LAST;
      wvf_pkg::FORM_64: hdr_last = wvf_pkg::CNT_HDR64_LAST;
      default:          hdr_last = wvf_pkg::CNT_HDR7_LAST;
    endcase
  end

  // header bytes after the first; only positions up to hdr_last are used
  always_comb begin
    hdr_byte = 8'h00;
    unique case (ent_r.form)
      wvf_pkg::FORM_16: begin
        unique case (cnt_r)
          4'd1:    hdr_byte = wvf_pkg::WS_LEN_CODE_16 | mflag;
          4'd2:    hdr_byte = ent_r.total[15:8];
          default: hdr_byte = ent_r.total[7:0];
        endcase
      end
      wvf_pkg::FORM_64: begin
        unique case (cnt_r)
          4'd1:    hdr_byte = wvf_pkg::WS_LEN_CODE_64 | mflag;
          4'd6:    hdr_byte = {7'd0, ent_r.total[24]};
          4'd7:    hdr_byte = ent_r.total[23:16];
          4'd8:    hdr_byte = ent_r.total[15:8];
          4'd9:    hdr_byte = ent_r.total[7:0];
          default: hdr_byte = 8'h00;
        endcase
      end
      default: hdr_byte = {1'b0, ent_r.total[6:0]} | mflag;
    endcase
  end

  always_comb begin
    unique case (cnt_r[3:2])
      2'd0:    rec_word = wvf_pkg::REC_MAGIC;
      2'd1:    rec_word = ent_r.seq;
      default: rec_word = templ | {8'h00, ent_r.plen};
    endcase
  end

  always_comb begin
    unique case (phase_r)
      2'd0:    mask_byte = ent_r.key[7:0];
      2'd1:    mask_byte = ent_r.key[15:8];
      2'd2:    mask_byte = ent_r.key[23:16];
      default: mask_byte = ent_r.key[31:24];
    endcase
  end

  // next state
  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    unique case (st_r)
      wvf_pkg::BK_IDLE: begin
        if (fire && q_rdata.is_start) begin
          st_nxt  = wvf_pkg::BK_HDR;
          cnt_nxt = 4'd1;
        end
      end
      wvf_pkg::BK_HDR: begin
        if (advance) begin
          if (cnt_r == hdr_last) begin
            st_nxt  = ent_r.cm ? wvf_pkg::BK_KEY : wvf_pkg::BK_REC;
            cnt_nxt = '0;
          end else begin
            cnt_nxt = cnt_r + 4'd1;
          end
        end
      end
      wvf_pkg::BK_KEY: begin
        if (advance) begin
          if (cnt_r == wvf_pkg::CNT_KEY_LAST) begin
            st_nxt  = wvf_pkg::BK_REC;
            cnt_nxt = '0;
          end else begin
            cnt_nxt = cnt_r + 4'd1;
          end
        end
      end
      wvf_pkg::BK_REC: begin
        if (advance) begin
          if (cnt_r == wvf_pkg::CNT_REC_LAST) begin
            st_nxt  = wvf_pkg::BK_IDLE;
            cnt_nxt = '0;
          end else begin
            cnt_nxt = cnt_r + 4'd1;
          end
        end
      end
      default: begin
        st_nxt  = wvf_pkg::BK_IDLE;
        cnt_nxt = '0;
      end
    endcase
  end

  // outputs
  always_comb begin
    load     = 1'b0;
    mask_use = 1'b0;
    raw_byte = 8'h00;
    hdr_nxt  = 1'b0;
    end_nxt  = 1'b0;
    unique case (st_r)
      wvf_pkg::BK_IDLE: begin
        load = fire;
        if (q_rdata.is_start) begin
          raw_byte = wvf_pkg::WS_FIN | wvf_pkg::WS_OP_BINARY;
          hdr_nxt  = 1'b1;
        end else begin
          raw_byte = q_rdata.data;
          mask_use = 1'b1;
          end_nxt  = q_rdata.last;
        end
      end
      wvf_pkg::BK_HDR: begin
        load     = advance;
        raw_byte = hdr_byte;
        hdr_nxt  = 1'b1;
      end
      wvf_pkg::BK_KEY: begin
        load     = advance;
        raw_byte = ent_r.key[cnt_r[1:0]*8 +: 8];
        hdr_nxt  = 1'b1;
      end
      wvf_pkg::BK_REC: begin
        load     = advance;
        raw_byte = rec_word[cnt_r[1:0]*8 +: 8];
        mask_use = 1'b1;
        end_nxt  = (cnt_r == wvf_pkg::CNT_REC_LAST) && (ent_r.plen == 24'd0);
      end
      default: begin
        load = 1'b0;
      end
    endcase

    byte_nxt  = raw_byte;
    phase_nxt = phase_r;
    if (mask_use && ent_r.cm) begin
      byte_nxt = raw_byte ^ mask_byte;
      if (load) begin
        phase_nxt = phase_r + 2'd1;
      end
    end
    if (fire && q_rdata.is_start) begin
      phase_nxt = 2'd0;
    end

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && q_rdata.is_start) begin
      ent_r <= q_rdata;
    end
    if (load) begin
      out_byte_r <= byte_nxt;
      out_hdr_r  <= hdr_nxt;
      out_end_r  <= end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= wvf_pkg::BK_IDLE;
      cnt_r       <= '0;
      phase_r     <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_key_only_masked: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == wvf_pkg::BK_KEY) |-> ent_r.cm)
    else $error("back: mask key bytes on an unmasked frame");

  a_hdr_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == wvf_pkg::BK_HDR) |-> ((cnt_r != '0) && (cnt_r <= hdr_last)))
    else $error("back: header byte counter out of range");

endmodule

`default_nettype wire

>>> verif/websocket_video_frame_framer_test.sv
// ----------------------------------------------------------------------------
// websocket_video_frame_framer_test
// Self-checking bench for the video frame WebSocket framer: drives start and
// payload beats with random idling on both sides, predicts every outgoing
// byte (header, record, masked payload) and checks them in order.
// ----------------------------------------------------------------------------
module websocket_video_frame_framer_test;
  timeunit 1ns;
  timeprecision 1ps;

  // kind codes the block drops
  localparam logic [1:0] KIND_DROP_2 = 2'd2;
  localparam logic [1:0] KIND_DROP_3 = 2'd3;

  localparam int NUM_ITEMS       = 280;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int IDLE_LIMIT      = 4000;
  localparam int DRAIN_CYCLES    = 32;

  typedef struct packed {
    logic [7:0] data;
    logic       hdr;
    logic       last;
  } frame_byte_t;

  // Tracks framer state and holds the bytes still owed by the block.
  class frame_byte_scoreboard;
    frame_byte_t expected_bytes[$];
    logic [31:0] seq_num;
    logic [23:0] bytes_left;
    logic [1:0]  mask_phase;
    logic [31:0] mask_key;
    bit          masking;
    bit          frame_open;
    int          errors;

    function new();
      seq_num    = '0;
      bytes_left = '0;
      mask_phase = '0;
      mask_key   = '0;
      masking    = 1'b0;
      frame_open = 1'b0;
      errors     = 0;
    endfunction

    function void push_byte(logic [7:0] data, bit hdr, bit last);
      frame_byte_t fb;
      fb.data = data;
      fb.hdr  = hdr;
      fb.last = last;
      expected_bytes.push_back(fb);
    endfunction

    function logic [7:0] apply_mask(logic [7:0] data);
      logic [7:0] res;
      res = data;
      if (masking) begin
        res = data ^ mask_key[mask_phase*8 +: 8];
        mask_phase = mask_phase + 2'd1;
      end
      return res;
    endfunction

    // Returns 1 when the beat produces output bytes.
    function bit note_beat(wvf_pkg::op_t op, logic [1:0] kind, logic [23:0] plen,
                           logic cm, logic [31:0] key, logic [7:0] data);
      logic [31:0] rec [3];
      logic [24:0] total;
      logic [7:0]  mflag;
      logic [7:0]  rb;
      if (op == wvf_pkg::OP_DATA) begin
        if (!frame_open || bytes_left == 0) return 1'b0;
        bytes_left = bytes_left - 24'd1;
        push_byte(apply_mask(data), 1'b0, bytes_left == 0);
        if (bytes_left == 0) frame_open = 1'b0;
        return 1'b1;
      end
      if (kind != wvf_pkg::KIND_DELTA && kind != wvf_pkg::KIND_KEY) return 1'b0;

      rec[0] = wvf_pkg::REC_MAGIC;
      rec[1] = seq_num;
      rec[2] = ((kind == wvf_pkg::KIND_KEY) ? wvf_pkg::TEMPL_KEY : wvf_pkg::TEMPL_DELTA) |
               {8'h00, plen};
      seq_num    = seq_num + 32'd1;
      masking    = cm;
      mask_key   = key;
      mask_phase = '0;
      bytes_left = plen;
      frame_open = plen != 0;

      total = {1'b0, plen} + wvf_pkg::REC_LEN;
      mflag = cm ? wvf_pkg::WS_MASK_FLAG : 8'h00;
      push_byte(wvf_pkg::WS_FIN | wvf_pkg::WS_OP_BINARY, 1'b1, 1'b0);
      if (total < wvf_pkg::WS_LEN7_LIMIT) begin
        push_byte(total[7:0] | mflag, 1'b1, 1'b0);
      end else if (total < wvf_pkg::WS_LEN16_LIMIT) begin
        push_byte(wvf_pkg::WS_LEN_CODE_16 | mflag, 1'b1, 1'b0);
        push_byte(total[15:8], 1'b1, 1'b0);
        push_byte(total[7:0], 1'b1, 1'b0);
      end else begin
        push_byte(wvf_pkg::WS_LEN_CODE_64 | mflag, 1'b1, 1'b0);
        for (int i = 0; i < 4; i++) push_byte(8'h00, 1'b1, 1'b0);
        push_byte({7'd0, total[24]}, 1'b1, 1'b0);
        push_byte(total[23:16], 1'b1, 1'b0);
        push_byte(total[15:8], 1'b1, 1'b0);
        push_byte(total[7:0], 1'b1, 1'b0);
      end
      if (cm) begin
        for (int i = 0; i < 4; i++) push_byte(key[i*8 +: 8], 1'b1, 1'b0);
      end
      // record goes out little-endian, masked from its first byte
      for (int i = 0; i < 12; i++) begin
        rb = rec[i/4][(i%4)*8 +: 8];
        push_byte(apply_mask(rb), 1'b0, plen == 0 && i == 11);
      end
      return 1'b1;
    endfunction

    function void check_byte(logic [7:0] data, logic hdr, logic last);
      frame_byte_t fb;
      if (expected_bytes.size() == 0) begin
        $error("out_byte: expected none, got %02h", data);
        errors++;
        return;
      end
      fb = expected_bytes.pop_front();
      if (data !== fb.data) begin
        $error("out_byte: expected %02h, got %02h", fb.data, data);
        errors++;
      end
      if (hdr !== fb.hdr) begin
        $error("out_in_header: expected %0b, got %0b", fb.hdr, hdr);
        errors++;
      end
      if (last !== fb.last) begin
        $error("out_frame_end: expected %0b, got %0b", fb.last, last);
        errors++;
      end
    endfunction

    function int pending_count();
      return expected_bytes.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic        in_op          = 1'b0;
  logic [1:0]  in_frame_kind  = '0;
  logic [23:0] in_payload_len = '0;
  logic        in_client_mask = 1'b0;
  logic [31:0] in_mask_key    = '0;
  logic [7:0]  in_data_byte   = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [7:0]  out_byte;
  logic        out_in_header;
  logic        out_frame_end;

  frame_byte_scoreboard sb = new();
  bit in_gaps_on   = 1'b1;
  bit out_gaps_on  = 1'b1;
  bit hold_off_req = 1'b0;
  int sent_items   = 0;
  int idle_cycles  = 0;

  websocket_video_frame_framer DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_frame_kind  (in_frame_kind),
    .in_payload_len (in_payload_len),
    .in_client_mask (in_client_mask),
    .in_mask_key    (in_mask_key),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_in_header  (out_in_header),
    .out_frame_end  (out_frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_beat(input wvf_pkg::op_t op, input logic [1:0] kind,
                           input logic [23:0] plen, input logic cm,
                           input logic [31:0] key, input logic [7:0] data);
    int gap;
    in_valid       <= 1'b1;
    in_op          <= op;
    in_frame_kind  <= kind;
    in_payload_len <= plen;
    in_client_mask <= cm;
    in_mask_key    <= key;
    in_data_byte   <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    void'(sb.note_beat(op, kind, plen, cm, key, data));
    sent_items++;
    gap = pick_gap(in_gaps_on);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_start(input logic [1:0] kind, input logic [23:0] plen, input logic cm,
                            input logic [31:0] key);
    send_beat(wvf_pkg::OP_START, kind, plen, cm, key, 8'($urandom));
  endtask

  // unused fields of a payload beat carry noise
  task automatic send_data(input logic [7:0] data);
    send_beat(wvf_pkg::OP_DATA, 2'($urandom), 24'($urandom), 1'($urandom), $urandom, data);
  endtask

  // receiver: checks each beat, stalls at random, honors hold-off requests
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst_n) continue;
      if (out_valid && out_ready) sb.check_byte(out_byte, out_in_header, out_frame_end);
      if (hold_off_req) begin
        out_ready    <= 1'b0;
        hold_off_req <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      if (stall_left == 0) stall_left = pick_gap(out_gaps_on);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** websocket_video_frame_framer: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          frame_idx;
    int          n;
    int          r;
    bit          hold;
    logic [1:0]  kind;
    logic [23:0] plen;
    logic        cm;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats
    send_start(wvf_pkg::KIND_DELTA, 24'd0, 1'b0, $urandom);     // empty frame
    send_start(wvf_pkg::KIND_KEY, 24'd0, 1'b1, 32'hFFFF_FFFF);  // empty, masked
    send_start(KIND_DROP_2, 24'd5, 1'b1, $urandom);             // dropped kinds
    send_start(KIND_DROP_3, 24'hFFFFFF, 1'b0, $urandom);
    send_data(8'h00);                                           // stray byte
    send_start(wvf_pkg::KIND_KEY, 24'd3, 1'b1, 32'hA5C3_0F96);
    send_data(8'hFF);
    send_start(KIND_DROP_2, 24'd1, 1'b0, $urandom);             // frame stays open
    send_data(8'h00);
    send_data(8'h5A);
    send_data(8'hFF);                                           // stray after end
    send_start(wvf_pkg::KIND_DELTA, 24'd113, 1'b0, $urandom);   // largest 7-bit form
    send_data(8'h81);
    send_start(wvf_pkg::KIND_DELTA, 24'd114, 1'b1, $urandom);   // smallest 16-bit form
    send_start(wvf_pkg::KIND_KEY, 24'd65523, 1'b0, $urandom);   // largest 16-bit form
    send_start(wvf_pkg::KIND_DELTA, 24'd65524, 1'b1, $urandom); // smallest 64-bit form
    send_start(wvf_pkg::KIND_KEY, 24'hFFFFFF, 1'b1, 32'h0000_0000);
    send_data(8'hFF);
    send_start(wvf_pkg::KIND_DELTA, 24'd1, 1'b1, $urandom);
    send_data(8'h00);

    // random frames
    frame_idx = 0;
    while (sent_items < NUM_ITEMS) begin
      in_gaps_on  = $urandom_range(0, 4) != 0;
      out_gaps_on = $urandom_range(0, 4) != 0;
      hold = (frame_idx == 0) || (frame_idx == 10);
      r = $urandom_range(0, 99);
      if (r < 8 && !hold) begin
        if ($urandom_range(0, 1)) send_start(2'($urandom_range(2, 3)), 24'($urandom),
                                             1'($urandom), $urandom);
        else send_data(8'($urandom));
      end else begin
        kind = 2'($urandom_range(0, 1));
        cm   = 1'($urandom);
        r    = $urandom_range(0, 99);
        if (r < 70) plen = 24'($urandom_range(0, 12));
        else if (r < 85) plen = 24'($urandom_range(13, 200));
        else if (r < 95) plen = 24'($urandom_range(65520, 65530));
        else plen = 24'($urandom);
        if (hold) begin
          // receiver holds off while the sender keeps pushing
          hold_off_req <= 1'b1;
          plen = 24'd60;
        end
        send_start(kind, plen, cm, $urandom);
        if (plen > 200) n = $urandom_range(0, 5);
        else if ($urandom_range(0, 9) == 0) n = $urandom_range(0, plen);
        else n = plen;
        for (int i = 0; i < n && sent_items < NUM_ITEMS; i++) begin
          if ($urandom_range(0, 99) < 2) send_start(2'($urandom_range(2, 3)), 24'($urandom),
                                                    1'($urandom), $urandom);
          send_data(8'($urandom));
        end
      end
      frame_idx++;
    end
    in_valid <= 1'b0;

    while (sb.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** websocket_video_frame_framer: PASSED **");
    end else begin
      $display("** websocket_video_frame_framer: FAILED **");
    end
    $finish;
  end

endmodule
